// File: design/multilevel_feedback_scheduler_top_macros.svh
// Assertion macros for the scheduler.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_TOP_MACROS_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_TOP_MACROS_SVH
// Implication checked at every edge outside reset.
`define MFS_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define MFS_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");
`endif

// File: design/mfs_pkg.sv
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared constants and types of the multilevel feedback scheduler.
// ----------------------------------------------------------------------------
package mfs_pkg;
  localparam int SLOTS      = 64;
  localparam int STAMP_BITS = 32;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);

  localparam logic [3:0] F_ADMIT  = 4'd0;
  localparam logic [3:0] F_BLOCK  = 4'd1;
  localparam logic [3:0] F_WAKE   = 4'd2;
  localparam logic [3:0] F_REMOVE = 4'd3;
  localparam logic [3:0] F_YIELD  = 4'd4;
  localparam logic [3:0] F_DEMOTE = 4'd5;
  localparam logic [3:0] F_LOWER  = 4'd6;
  localparam logic [3:0] F_BOOST  = 4'd7;
  localparam logic [3:0] F_SETPRI = 4'd8;
  localparam logic [3:0] F_LOCK   = 4'd9;
  localparam logic [3:0] F_UNLOCK = 4'd10;
  localparam logic [3:0] F_QUERY  = 4'd11;
  localparam logic [3:0] F_PICK   = 4'd12;

  localparam logic [2:0] S_OK      = 3'd0;
  localparam logic [2:0] S_BADPRI  = 3'd1;
  localparam logic [2:0] S_LOCKED  = 3'd2;
  localparam logic [2:0] S_NOTLOCK = 3'd3;
  localparam logic [2:0] S_NONE    = 3'd4;

  localparam logic [1:0] TS_UNUSED   = 2'd0;
  localparam logic [1:0] TS_BLOCKED  = 2'd1;
  localparam logic [1:0] TS_RUNNABLE = 2'd2;
  localparam logic [1:0] LVL_LOCKED  = 2'd3;

  typedef struct packed {
    logic [1:0]            st;
    logic [1:0]            lvl;
    logic [1:0]            pri;
    logic                  ret;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_RD    = 9'b000000010,
    ST_MOD   = 9'b000000100,
    ST_BOOST = 9'b000001000,
    ST_SCAN  = 9'b000010000,
    ST_RR    = 9'b000100000,
    ST_CLRRD = 9'b001000000,
    ST_CLR   = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;
endpackage

// File: design/multilevel_feedback_scheduler_top.sv
// Flow: a single-slot event word is read, modified and written back, then
// out_valid rises; a boost or a pick walks the full table first, and a pick may
// then reread and clear a returned mark or make a round robin pass from the cursor.
// Throughput: one word at a time; the next word is taken as the result goes out,
// and a result still waiting on out_ready holds the block in its output state.
// Reset: after reset the table is swept clear slot by slot, no word accepted then.
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_top
// Three-level feedback scheduler over a task table held in one memory.
// ----------------------------------------------------------------------------
`include "multilevel_feedback_scheduler_top_macros.svh"
module multilevel_feedback_scheduler_top import mfs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_func,
  input  logic [5:0]  in_slot,
  input  logic [31:0] in_stamp,
  input  logic [2:0]  in_new_priority,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [5:0]  out_chosen_slot,
  output logic [1:0]  out_chosen_level,
  output logic        out_found
);
  entry_t mem [SLOTS];
  entry_t rd_q;
  entry_t rst_e;
  logic   we;
  logic [SLOT_W-1:0] wa, ra;
  entry_t wd;

  state_t state_r, state_nxt;
  logic              init_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] rr_idx;
  logic [3:0]        func_r;
  logic [SLOT_W-1:0] slot_r;
  logic              svalid_r;
  logic [STAMP_BITS-1:0] stamp_r;
  logic [2:0]        np_r;
  logic              lock_r, lock_nxt;
  logic [SLOT_W-1:0] cur_r, cur_nxt;
  // scan results
  logic              lk_f_r, ret_f_r, b0_r, b1_r, b2_f_r;
  logic [SLOT_W-1:0] lk_i_r, ret_i_r, b2_i_r;
  logic [1:0]        b2_p_r;
  logic [STAMP_BITS-1:0] b2_s_r;
  logic              lk_f_nxt, ret_f_nxt, b0_nxt, b1_nxt, b2_f_nxt;
  logic [SLOT_W-1:0] lk_i_nxt, ret_i_nxt, b2_i_nxt;
  logic [1:0]        b2_p_nxt;
  logic [STAMP_BITS-1:0] b2_s_nxt;
  logic              rrlvl_r, rrlvl_nxt;
  logic [2:0] o_st_r, o_st_nxt;
  logic [5:0] o_sl_r, o_sl_nxt;
  logic [1:0] o_lv_r, o_lv_nxt;
  logic       o_f_r, o_f_nxt;
  logic       oval_r, oval_nxt;
  logic [2:0] q_st_r;
  logic [5:0] q_sl_r;
  logic [1:0] q_lv_r;
  logic       q_f_r;
  logic       run;

  assign rst_e = '{st: TS_UNUSED, lvl: 2'd0, pri: 2'd3, ret: 1'b0, stamp: '0};

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  assign in_ready  = (state_r == ST_IDLE) && init_r;
  assign out_valid = oval_r;
  assign out_status = q_st_r;
  assign out_chosen_slot = q_sl_r;
  assign out_chosen_level = q_lv_r;
  assign out_found = q_f_r;
  assign run = rd_q.st == TS_RUNNABLE;
  assign idx = cnt_r[SLOT_W-1:0];
  assign rr_idx = cur_r + cnt_r[SLOT_W-1:0];

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r;
    lock_nxt = lock_r; cur_nxt = cur_r; rrlvl_nxt = rrlvl_r;
    lk_f_nxt = lk_f_r; lk_i_nxt = lk_i_r; ret_f_nxt = ret_f_r; ret_i_nxt = ret_i_r;
    b0_nxt = b0_r; b1_nxt = b1_r; b2_f_nxt = b2_f_r; b2_i_nxt = b2_i_r;
    b2_p_nxt = b2_p_r; b2_s_nxt = b2_s_r;
    o_st_nxt = o_st_r; o_sl_nxt = o_sl_r; o_lv_nxt = o_lv_r; o_f_nxt = o_f_r;
    oval_nxt = oval_r && !out_ready;
    we = 1'b0; wa = slot_r; wd = rd_q; ra = slot_r;
    unique case (state_r)
      ST_IDLE: begin
        ra = in_slot;
        if (!init_r) begin
          we = 1'b1; wa = cnt_r[SLOT_W-1:0]; wd = rst_e;
          cnt_nxt = cnt_r + 1'b1;
        end else if (in_valid && in_ready) begin
          o_st_nxt = S_OK; o_sl_nxt = '0; o_lv_nxt = '0; o_f_nxt = 1'b0;
          cnt_nxt = '0;
          if (in_func == F_BOOST || in_func == F_PICK) begin
            ra = '0;
            lk_f_nxt = 1'b0; ret_f_nxt = 1'b0; b0_nxt = 1'b0; b1_nxt = 1'b0;
            b2_f_nxt = 1'b0;
            state_nxt = (in_func == F_BOOST) ? ST_BOOST : ST_SCAN;
            if (in_func == F_BOOST) lock_nxt = 1'b0;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: state_nxt = ST_MOD;
      ST_MOD: begin
        state_nxt = ST_OUT;
        case (func_r)
          F_ADMIT: if (svalid_r && rd_q.st == TS_UNUSED) begin
            we = 1'b1; wd = rst_e; wd.st = TS_RUNNABLE; wd.stamp = stamp_r;
          end
          F_BLOCK: if (rd_q.st == TS_RUNNABLE) begin we = 1'b1; wd.st = TS_BLOCKED; end
          F_WAKE: if (rd_q.st == TS_BLOCKED) begin we = 1'b1; wd.st = TS_RUNNABLE; end
          F_REMOVE: if (rd_q.st != TS_UNUSED) begin
            if (rd_q.lvl == LVL_LOCKED) lock_nxt = 1'b0;
            we = 1'b1; wd = rst_e;
          end
          F_YIELD: if (rd_q.st != TS_UNUSED) begin we = 1'b1; wd.st = TS_RUNNABLE; end
          F_DEMOTE: if (rd_q.st != TS_UNUSED && rd_q.lvl != LVL_LOCKED) begin
            we = 1'b1; wd.st = TS_RUNNABLE; wd.stamp = stamp_r;
            if (rd_q.lvl < 2'd2) wd.lvl = rd_q.lvl + 2'd1;
          end
          F_LOWER: if (rd_q.st != TS_UNUSED && rd_q.lvl != LVL_LOCKED) begin
            we = 1'b1; wd.st = TS_RUNNABLE;
            if (rd_q.pri != 2'd0) wd.pri = rd_q.pri - 2'd1;
          end
          F_SETPRI: begin
            if (np_r > 3'd3) o_st_nxt = S_BADPRI;
            else if (rd_q.st != TS_UNUSED) begin we = 1'b1; wd.pri = np_r[1:0]; end
          end
          F_LOCK: begin
            if (lock_r) o_st_nxt = S_LOCKED;
            else if (rd_q.st != TS_UNUSED) begin
              we = 1'b1; wd.lvl = LVL_LOCKED; lock_nxt = 1'b1;
            end
          end
          F_UNLOCK: begin
            if (rd_q.st == TS_UNUSED || rd_q.lvl != LVL_LOCKED) o_st_nxt = S_NOTLOCK;
            else begin
              we = 1'b1; wd.lvl = 2'd0; wd.pri = 2'd3; wd.ret = 1'b1; lock_nxt = 1'b0;
            end
          end
          F_QUERY: begin
            o_sl_nxt = slot_r; o_lv_nxt = rd_q.lvl;
          end
          default: ;
        endcase
      end
      // slot cnt comes back while slot cnt+1 is read
      ST_BOOST: begin
        ra = idx + 1'b1;
        we = 1'b1; wa = idx;
        wd = rd_q; if (rd_q.lvl == LVL_LOCKED) wd.ret = 1'b1;
        wd.pri = 2'd3; wd.lvl = 2'd0; wd.stamp = stamp_r;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SLOTS - 1)) state_nxt = ST_OUT;
      end
      ST_SCAN: begin
        ra = idx + 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (run && rd_q.lvl == LVL_LOCKED && !lk_f_r) begin
          lk_f_nxt = 1'b1; lk_i_nxt = idx;
        end
        if (run && rd_q.ret && !ret_f_r) begin
          ret_f_nxt = 1'b1; ret_i_nxt = idx;
        end
        if (run && rd_q.lvl == 2'd0) b0_nxt = 1'b1;
        if (run && rd_q.lvl == 2'd1) b1_nxt = 1'b1;
        if (run && rd_q.lvl == 2'd2 && (!b2_f_r || rd_q.pri < b2_p_r ||
            (rd_q.pri == b2_p_r && rd_q.stamp < b2_s_r))) begin
          b2_f_nxt = 1'b1; b2_i_nxt = idx;
          b2_p_nxt = rd_q.pri; b2_s_nxt = rd_q.stamp;
        end
        if (cnt_r == CNT_W'(SLOTS - 1)) begin
          state_nxt = ST_OUT;
          if (lk_f_nxt) begin
            o_f_nxt = 1'b1; o_sl_nxt = 6'(lk_i_nxt); o_lv_nxt = LVL_LOCKED;
          end else if (b0_nxt || b1_nxt) begin
            if (ret_f_nxt) begin
              // clear the returned mark, level comes from reread
              state_nxt = ST_CLRRD;
            end else begin
              // start the round robin read at the cursor
              ra = cur_r;
              rrlvl_nxt = !b0_nxt; cnt_nxt = '0; state_nxt = ST_RR;
            end
          end else if (b2_f_nxt) begin
            o_f_nxt = 1'b1; o_sl_nxt = 6'(b2_i_nxt); o_lv_nxt = 2'd2;
          end else begin
            o_st_nxt = S_NONE;
          end
        end
      end
      ST_CLRRD: begin ra = ret_i_r; state_nxt = ST_CLR; end
      ST_CLR: begin
        we = 1'b1; wa = ret_i_r; wd = rd_q; wd.ret = 1'b0;
        o_f_nxt = 1'b1; o_sl_nxt = 6'(ret_i_r); o_lv_nxt = rd_q.lvl;
        state_nxt = ST_OUT;
      end
      // round robin pass from the cursor
      ST_RR: begin
        ra = rr_idx + 1'b1;
        if (run && rd_q.lvl == {1'b0, rrlvl_r}) begin
          o_f_nxt = 1'b1; o_sl_nxt = 6'(rr_idx); o_lv_nxt = rd_q.lvl;
          cur_nxt = rr_idx + 1'b1;
          state_nxt = ST_OUT;
        end else if (cnt_r == CNT_W'(SLOTS - 1)) begin
          o_st_nxt = S_NONE; state_nxt = ST_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      // hold until the previous word has left the output register
      ST_OUT: begin
        if (!oval_r || out_ready) begin
          oval_nxt = 1'b1; state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; init_r <= 1'b0; cnt_r <= '0; oval_r <= 1'b0;
      lock_r <= 1'b0; cur_r <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; oval_r <= oval_nxt;
      lock_r <= lock_nxt; cur_r <= cur_nxt;
      if (!init_r && cnt_r == CNT_W'(SLOTS - 1)) init_r <= 1'b1;
    end
  end

  // hold event fields and scan results
  always_ff @(posedge clk) begin
    rrlvl_r <= rrlvl_nxt;
    lk_f_r <= lk_f_nxt; lk_i_r <= lk_i_nxt; ret_f_r <= ret_f_nxt; ret_i_r <= ret_i_nxt;
    b0_r <= b0_nxt; b1_r <= b1_nxt; b2_f_r <= b2_f_nxt; b2_i_r <= b2_i_nxt;
    b2_p_r <= b2_p_nxt; b2_s_r <= b2_s_nxt;
    o_st_r <= o_st_nxt; o_sl_r <= o_sl_nxt; o_lv_r <= o_lv_nxt; o_f_r <= o_f_nxt;
    if (state_r == ST_OUT && (!oval_r || out_ready)) begin
      q_st_r <= o_st_r; q_sl_r <= o_sl_r; q_lv_r <= o_lv_r; q_f_r <= o_f_r;
    end
    if (in_valid && in_ready) begin
      func_r <= in_func; slot_r <= SLOT_W'(in_slot);
      svalid_r <= {26'd0, in_slot} < 32'(SLOTS);
      stamp_r <= STAMP_BITS'(in_stamp); np_r <= in_new_priority;
    end
  end

  `MFS_ASSERT_IMP(a_ready_idle, in_ready, state_r == ST_IDLE)
  `MFS_ASSERT_IMP(a_no_accept_init, !init_r, !in_ready)
  `MFS_ASSERT_NEXT(a_out_from_done, state_r == ST_OUT, oval_r)
  `MFS_ASSERT_NEXT(a_out_hold, oval_r && !out_ready, oval_r)
endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the feedback scheduler against a built-in predictor: directed and random
// event words with idling on both channels, every result compared in order.
// ----------------------------------------------------------------------------
module tb;
  import mfs_pkg::*;

  typedef struct packed {
    logic [3:0]  func;
    logic [5:0]  slot;
    logic [31:0] stamp;
    logic [2:0]  npri;
  } event_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] cslot;
    logic [1:0] clevel;
    logic       found;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  in_func;
  logic [5:0]  in_slot;
  logic [31:0] in_stamp;
  logic [2:0]  in_new_priority;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [5:0]  out_chosen_slot;
  logic [1:0]  out_chosen_level;
  logic        out_found;

  multilevel_feedback_scheduler_top dut (.*);

  // predictor copy of the task table
  logic [1:0]  m_st   [SLOTS];
  logic [1:0]  m_lvl  [SLOTS];
  logic [1:0]  m_pri  [SLOTS];
  logic [31:0] m_stm  [SLOTS];
  logic        m_ret  [SLOTS];
  logic        m_lock;
  int          m_cur;

  event_t  pending_events[$];
  answer_t expected_answers[$];
  int      errors = 0;
  int      send_idle;
  int      recv_idle;
  bit      hold_send;
  bit      in_taken;

  function automatic void clear_task(int i);
    m_st[i] = TS_UNUSED;
    m_lvl[i] = 2'd0;
    m_pri[i] = 2'd3;
    m_stm[i] = '0;
    m_ret[i] = 1'b0;
  endfunction

  // pick order: locked, returned, round robin at level 0/1, then level 2
  function automatic int choose_task();
    int i, k, best, lv;
    bit b0, b1;
    best = SLOTS;
    b0 = 0;
    b1 = 0;
    for (i = 0; i < SLOTS; i++)
      if (m_st[i] == TS_RUNNABLE && m_lvl[i] == LVL_LOCKED) return i;
    for (i = 0; i < SLOTS; i++) begin
      if (m_st[i] != TS_RUNNABLE) continue;
      if (m_lvl[i] == 2'd0) b0 = 1;
      else if (m_lvl[i] == 2'd1) b1 = 1;
    end
    if (b0 || b1) begin
      lv = b0 ? 0 : 1;
      for (i = 0; i < SLOTS; i++)
        if (m_st[i] == TS_RUNNABLE && m_ret[i]) begin
          m_ret[i] = 1'b0;
          return i;
        end
      for (k = 0; k < SLOTS; k++) begin
        i = (m_cur + k) % SLOTS;
        if (m_st[i] == TS_RUNNABLE && m_lvl[i] == lv) begin
          m_cur = (i + 1) % SLOTS;
          return i;
        end
      end
      return SLOTS;
    end
    for (i = 0; i < SLOTS; i++) begin
      if (m_st[i] != TS_RUNNABLE || m_lvl[i] != 2'd2) continue;
      if (best == SLOTS || m_pri[i] < m_pri[best] ||
          (m_pri[i] == m_pri[best] && m_stm[i] < m_stm[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic answer_t schedule_event(event_t e);
    answer_t a;
    int s, i;
    bit used;
    a = '0;
    s = e.slot;
    used = m_st[s] != TS_UNUSED;
    case (e.func)
      F_ADMIT: if (!used) begin
        clear_task(s);
        m_st[s] = TS_RUNNABLE;
        m_stm[s] = e.stamp;
      end
      F_BLOCK: if (m_st[s] == TS_RUNNABLE) m_st[s] = TS_BLOCKED;
      F_WAKE: if (m_st[s] == TS_BLOCKED) m_st[s] = TS_RUNNABLE;
      F_REMOVE: if (used) begin
        if (m_lvl[s] == LVL_LOCKED) m_lock = 1'b0;
        clear_task(s);
      end
      F_YIELD: if (used) m_st[s] = TS_RUNNABLE;
      F_DEMOTE: if (used && m_lvl[s] != LVL_LOCKED) begin
        m_st[s] = TS_RUNNABLE;
        m_stm[s] = e.stamp;
        if (m_lvl[s] < 2) m_lvl[s] = m_lvl[s] + 2'd1;
      end
      F_LOWER: if (used && m_lvl[s] != LVL_LOCKED) begin
        m_st[s] = TS_RUNNABLE;
        if (m_pri[s] > 0) m_pri[s] = m_pri[s] - 2'd1;
      end
      F_BOOST: begin
        for (i = 0; i < SLOTS; i++) begin
          if (m_lvl[i] == LVL_LOCKED) m_ret[i] = 1'b1;
          m_pri[i] = 2'd3;
          m_lvl[i] = 2'd0;
          m_stm[i] = e.stamp;
        end
        m_lock = 1'b0;
      end
      F_SETPRI: begin
        if (e.npri > 3) a.status = S_BADPRI;
        else if (used) m_pri[s] = e.npri[1:0];
      end
      F_LOCK: begin
        if (m_lock) a.status = S_LOCKED;
        else if (used) begin
          m_lvl[s] = LVL_LOCKED;
          m_lock = 1'b1;
        end
      end
      F_UNLOCK: begin
        if (!used || m_lvl[s] != LVL_LOCKED) a.status = S_NOTLOCK;
        else begin
          m_lvl[s] = 2'd0;
          m_pri[s] = 2'd3;
          m_ret[s] = 1'b1;
          m_lock = 1'b0;
        end
      end
      F_QUERY: begin
        a.cslot = e.slot;
        a.clevel = m_lvl[s];
      end
      F_PICK: begin
        i = choose_task();
        if (i < SLOTS) begin
          a.cslot = i[5:0];
          a.clevel = m_lvl[i];
          a.found = 1'b1;
        end else a.status = S_NONE;
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic event_t make_event(logic [3:0] f, int s);
    event_t e;
    e.func = f;
    e.slot = s[5:0];
    e.stamp = $urandom();
    e.npri = 3'($urandom_range(0, 7));
    return e;
  endfunction

  // weighted random event: mostly scheduler traffic on a few slots
  function automatic event_t random_event();
    int r, s;
    logic [3:0] f;
    r = $urandom_range(0, 99);
    s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 11);
    if (r < 18) f = F_ADMIT;
    else if (r < 40) f = F_PICK;
    else if (r < 45) f = F_BLOCK;
    else if (r < 50) f = F_WAKE;
    else if (r < 54) f = F_REMOVE;
    else if (r < 58) f = F_YIELD;
    else if (r < 66) f = F_DEMOTE;
    else if (r < 71) f = F_LOWER;
    else if (r < 73) f = F_BOOST;
    else if (r < 78) f = F_SETPRI;
    else if (r < 84) f = F_LOCK;
    else if (r < 89) f = F_UNLOCK;
    else if (r < 95) f = F_QUERY;
    else f = 4'($urandom_range(13, 15));
    return make_event(f, s);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // drive the event channel at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (!hold_send && pending_events.size() > 0 &&
          $urandom_range(0, 99) >= send_idle) begin
        in_valid <= 1'b1;
        {in_func, in_slot, in_stamp, in_new_priority} <= pending_events.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // predict on event acceptance, check on result acceptance
  always @(posedge clk) begin
    answer_t got, want;
    int j;
    in_taken = rst_n && in_valid && in_ready;
    if (!rst_n) begin
      for (j = 0; j < SLOTS; j++) clear_task(j);
      m_lock = 1'b0;
      m_cur = 0;
    end
    if (in_taken)
      expected_answers.push_back(schedule_event(
        {in_func, in_slot, in_stamp, in_new_priority}));
    if (rst_n && out_valid && out_ready) begin
      got = {out_status, out_chosen_slot, out_chosen_level, out_found};
      if (expected_answers.size() == 0) begin
        errors++;
        $display("%0t expected no result got %h", $time, got);
      end else begin
        want = expected_answers.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t expected st=%0d slot=%0d lvl=%0d found=%0d",
                   $time, want.status, want.cslot, want.clevel, want.found,
                   " got st=%0d slot=%0d lvl=%0d found=%0d",
                   got.status, got.cslot, got.clevel, got.found);
        end
      end
    end
  end

  initial begin
    int i;
    rst_n = 1'b0;
    hold_send = 1'b0;
    send_idle = 38;
    recv_idle = 85;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty pick, extremes, lock and boost cases
    pending_events.push_back(make_event(F_PICK, 0));
    pending_events.push_back({F_ADMIT, 6'd63, 32'hFFFF_FFFF, 3'd7});
    pending_events.push_back({F_ADMIT, 6'd0, 32'h0, 3'd0});
    pending_events.push_back({F_ADMIT, 6'd0, 32'h5, 3'd0});
    pending_events.push_back({F_SETPRI, 6'd0, 32'h0, 3'd4});
    pending_events.push_back({F_SETPRI, 6'd63, 32'h0, 3'd0});
    pending_events.push_back({F_DEMOTE, 6'd63, 32'h10, 3'd0});
    pending_events.push_back({F_DEMOTE, 6'd63, 32'h20, 3'd0});
    pending_events.push_back({F_DEMOTE, 6'd63, 32'h30, 3'd0});
    pending_events.push_back({F_LOWER, 6'd63, 32'h0, 3'd0});
    pending_events.push_back({F_BLOCK, 6'd0, 32'h0, 3'd0});
    pending_events.push_back(make_event(F_PICK, 0));
    pending_events.push_back({F_WAKE, 6'd0, 32'h0, 3'd0});
    pending_events.push_back({F_LOCK, 6'd63, 32'h0, 3'd0});
    pending_events.push_back({F_LOCK, 6'd0, 32'h0, 3'd0});
    pending_events.push_back({F_QUERY, 6'd63, 32'h0, 3'd0});
    pending_events.push_back(make_event(F_PICK, 0));
    pending_events.push_back({F_UNLOCK, 6'd5, 32'h0, 3'd0});
    pending_events.push_back({F_YIELD, 6'd5, 32'h0, 3'd0});
    pending_events.push_back({F_BOOST, 6'd0, 32'h77, 3'd0});
    pending_events.push_back(make_event(F_PICK, 0));
    pending_events.push_back({F_LOCK, 6'd0, 32'h0, 3'd0});
    pending_events.push_back({F_UNLOCK, 6'd0, 32'h0, 3'd0});
    pending_events.push_back({F_REMOVE, 6'd63, 32'h0, 3'd0});
    pending_events.push_back({4'd15, 6'd0, 32'h0, 3'd0});
    for (i = 0; i < 400; i++) pending_events.push_back(random_event());
    wait (pending_events.size() == 0);

    // hold the sender until the block drains
    hold_send = 1'b1;
    wait (expected_answers.size() == 0 && !in_valid);
    hold_send = 1'b0;
    send_idle = 85;
    recv_idle = 38;
    for (i = 0; i < 425; i++) pending_events.push_back(random_event());
    wait (pending_events.size() == 0);
    send_idle = 0;
    recv_idle = 0;
    for (i = 0; i < 425; i++) pending_events.push_back(random_event());
    wait (pending_events.size() == 0);
    @(posedge clk);
    wait (!in_valid && expected_answers.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_answers.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
